FILE: rtl/rqlm_pkg.sv
// Shared types and constants of the run queue latency monitor.
`timescale 1ns / 1ps

package rqlm_pkg;

    // Pending-wakeup table geometry.
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths.
    localparam int ID_W   = 22;
    localparam int TIME_W = 64;
    localparam int CPU_W  = 8;
    localparam int LAT_W  = 55;
    localparam int MIN_W  = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LATENCY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TASK = CFG_IDX_W'(1);

    // Event kinds.
    localparam logic MODE_WAKEUP = 1'b0;
    localparam logic MODE_SWITCH = 1'b1;

    // Nanosecond to microsecond conversion by reciprocal multiplication.
    // One thousand is eight times 125: the dividend is shifted down by three
    // and multiplied by the rounded-up reciprocal of 125 scaled by 2^68, and
    // the product from bit 68 up is the exact quotient for any dividend
    // below 2^61.
    localparam int NS_PER_US    = 1000;
    localparam int DIV_PRESHIFT = 3;
    localparam int DIV_DENOM    = NS_PER_US >> DIV_PRESHIFT;
    localparam int DIV_SHIFT    = 68;
    localparam logic [63:0] DIV_RECIP =
        64'(((128'd1 << DIV_SHIFT) + 128'(DIV_DENOM - 1)) / 128'(DIV_DENOM));

    // Command queue between front and back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   task_id;
        logic [ID_W-1:0]   outgoing_id;
        logic              outgoing_runnable;
        logic [TIME_W-1:0] now_ns;
        logic [CPU_W-1:0]  cpu_index;
    } t_in_item;

    typedef struct packed {
        logic [CPU_W-1:0] cpu_out;
        logic [ID_W-1:0]  incoming_out;
        logic [ID_W-1:0]  outgoing_out;
        logic [LAT_W-1:0] latency_us;
    } t_out_item;

    // Classified work for the back end.
    typedef struct packed {
        logic              do_rec;
        logic [ID_W-1:0]   rec_id;
        logic              do_look;
        logic [ID_W-1:0]   look_id;
        logic [ID_W-1:0]   outgoing_id;
        logic [TIME_W-1:0] now_ns;
        logic [CPU_W-1:0]  cpu_index;
    } t_cmd;

    // One word of the table memory.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   key;
        logic [TIME_W-1:0] stamp;
    } t_entry;

endpackage

FILE: rtl/rqlm_front.sv
// Front end: accepts events, applies the record filter and queues commands.
`timescale 1ns / 1ps

module rqlm_front
    import rqlm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_in_item        i_data,
    input  logic [ID_W-1:0] i_target_task,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output t_cmd            o_cmd
);

    t_cmd                  w_cmd;
    logic                  w_push;
    logic                  w_pop;
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] n_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_PTR_W-1:0] n_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_fill;
    logic [CMDQ_CNT_W-1:0] n_fill;
    t_cmd                  r_q [CMDQ_DEPTH];

    // Id zero is never tracked; a nonzero target restricts tracking to one id.
    function automatic logic may_record(input logic [ID_W-1:0] id,
                                        input logic [ID_W-1:0] target);
        return (id != '0) && ((target == '0) || (target == id));
    endfunction

    function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
        return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + CMDQ_PTR_W'(1);
    endfunction

    always_comb begin
        w_cmd.now_ns      = i_data.now_ns;
        w_cmd.cpu_index   = i_data.cpu_index;
        w_cmd.outgoing_id = i_data.outgoing_id;
        w_cmd.look_id     = i_data.task_id;
        if (i_data.mode == MODE_SWITCH) begin
            w_cmd.do_rec  = i_data.outgoing_runnable
                            && may_record(i_data.outgoing_id, i_target_task);
            w_cmd.rec_id  = i_data.outgoing_id;
            w_cmd.do_look = (i_data.task_id != '0);
        end else begin
            w_cmd.do_rec  = may_record(i_data.task_id, i_target_task);
            w_cmd.rec_id  = i_data.task_id;
            w_cmd.do_look = 1'b0;
        end
    end

    assign o_stall     = (r_fill == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Events that leave nothing to do are taken and dropped here.
    assign w_push = i_valid && !o_stall && (w_cmd.do_rec || w_cmd.do_look);
    assign w_pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = w_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_fill   = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + CMDQ_CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_fill = r_fill - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

FILE: rtl/rqlm_div1000.sv
// Multicycle divider of a 64-bit nanosecond count by one thousand.
`timescale 1ns / 1ps

module rqlm_div1000
    import rqlm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    output logic              o_done,
    output logic [LAT_W-1:0]  o_quotient
);

    localparam int         HALF_W    = 32;
    localparam int         ACC_W     = 66;
    localparam logic [1:0] STEP_LAST = 2'd3;

    logic                r_busy;
    logic                r_done;
    logic [1:0]          r_step;
    logic [TIME_W-1:0]   r_y;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [HALF_W-1:0]   w_a;
    logic [HALF_W-1:0]   w_b;
    logic [2*HALF_W-1:0] w_prod;
    logic [ACC_W-1:0]    w_sum;

    // One 32 by 32 bit partial product per cycle: low by low, low by high,
    // high by low, then high by high. Low product bits are dropped as soon
    // as no later partial product can carry into them, so the accumulator
    // ends up holding the full product shifted down by 64.
    assign w_a    = r_step[1] ? r_y[2*HALF_W-1:HALF_W] : r_y[HALF_W-1:0];
    assign w_b    = r_step[0] ? DIV_RECIP[2*HALF_W-1:HALF_W] : DIV_RECIP[HALF_W-1:0];
    assign w_prod = w_a * w_b;
    assign w_sum  = r_acc + ACC_W'(w_prod);

    always_comb begin
        case (r_step)
            2'd0: begin
                n_acc = ACC_W'(w_prod[2*HALF_W-1:HALF_W]);
            end
            2'd2: begin
                n_acc = w_sum >> HALF_W;
            end
            default: begin
                n_acc = w_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_y <= i_dividend >> DIV_PRESHIFT;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc[DIV_SHIFT-2*HALF_W +: LAT_W];

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy)
        else $error("divider restarted while a division is running");

endmodule

FILE: rtl/rqlm_back.sv
// Back end: hashed wakeup table with linear probing, latency check and result register.
`timescale 1ns / 1ps

module rqlm_back
    import rqlm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    input  logic [MIN_W-1:0] i_min_latency,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_data
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_PROBE_GO = 4'd2;
    localparam logic [3:0] ST_PROBE    = 4'd3;
    localparam logic [3:0] ST_DIV_GO   = 4'd4;
    localparam logic [3:0] ST_DIV_WAIT = 4'd5;
    localparam logic [3:0] ST_EMIT     = 4'd6;
    localparam logic [3:0] ST_DEL_RD   = 4'd7;
    localparam logic [3:0] ST_DEL_EVAL = 4'd8;
    localparam logic [3:0] ST_DEL_END  = 4'd9;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              r_is_look;
    logic              n_is_look;
    logic [IDX_W-1:0]  r_addr;
    logic [IDX_W-1:0]  n_addr;
    logic [IDX_W-1:0]  r_steps;
    logic [IDX_W-1:0]  n_steps;
    logic [IDX_W-1:0]  r_hole;
    logic [IDX_W-1:0]  n_hole;
    logic [TIME_W-1:0] r_stamp;
    logic [TIME_W-1:0] n_stamp;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;

    logic [ID_W-1:0]   w_probe_id;
    logic [IDX_W-1:0]  w_home;
    logic [IDX_W-1:0]  w_next_addr;
    logic              w_hit;
    logic              w_last;
    logic              w_move;
    logic              w_div_start;
    logic              w_div_done;
    logic [TIME_W-1:0] w_delta;
    logic [LAT_W-1:0]  w_quo;

    // Home slot of an id: XOR fold of the id onto the index width, reduced
    // once into range when the table size is not a power of two.
    function automatic logic [IDX_W-1:0] home_slot(input logic [ID_W-1:0] id);
        logic [IDX_W-1:0] h;
        logic [IDX_W:0]   w;
        h = '0;
        for (int b = 0; b < ID_W; b++) begin
            h[b % IDX_W] = h[b % IDX_W] ^ id[b];
        end
        w = {1'b0, h};
        if (w >= (IDX_W+1)'(TABLE_ENTRIES)) begin
            w = w - (IDX_W+1)'(TABLE_ENTRIES);
        end
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] a);
        return (a == LAST_SLOT) ? '0 : a + IDX_W'(1);
    endfunction

    // Forward distance from slot a to slot b around the table.
    function automatic logic [IDX_W-1:0] slot_dist(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
        logic [IDX_W:0] d;
        if (b >= a) begin
            d = {1'b0, b} - {1'b0, a};
        end else begin
            d = {1'b0, b} + (IDX_W+1)'(TABLE_ENTRIES) - {1'b0, a};
        end
        return d[IDX_W-1:0];
    endfunction

    rqlm_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_delta),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_probe_id  = r_is_look ? r_cmd.look_id : r_cmd.rec_id;
    assign w_home      = home_slot(w_probe_id);
    assign w_next_addr = next_slot(r_addr);
    assign w_hit       = r_rd.valid && (r_rd.key == w_probe_id);
    assign w_last      = (r_steps == LAST_SLOT);
    assign w_delta     = r_cmd.now_ns - r_stamp;

    // During the delete scan, an entry moves back into the hole when the
    // hole lies on its probe path from its home slot.
    assign w_move = slot_dist(r_hole, r_addr) <= slot_dist(home_slot(r_rd.key), r_addr);

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_is_look   = r_is_look;
        n_addr      = r_addr;
        n_steps     = r_steps;
        n_hole      = r_hole;
        n_stamp     = r_stamp;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_addr;
        w_wr_data   = r_rd;
        w_div_start = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_data = '0;
                if (r_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = w_next_addr;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_is_look = !i_cmd.do_rec;
                    n_state   = ST_PROBE_GO;
                end
            end
            ST_PROBE_GO: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_home;
                n_addr    = w_home;
                n_steps   = '0;
                n_state   = ST_PROBE;
            end
            ST_PROBE: begin
                if (w_hit || !r_rd.valid || w_last) begin
                    if (!r_is_look) begin
                        // Record: overwrite a known id or claim the empty slot;
                        // a full table without the id drops the record.
                        if (w_hit || !r_rd.valid) begin
                            w_wr_en         = 1'b1;
                            w_wr_data.valid = 1'b1;
                            w_wr_data.key   = w_probe_id;
                            w_wr_data.stamp = r_cmd.now_ns;
                        end
                        if (!w_hit && !r_rd.valid) begin
                            n_count = r_count + CNT_W'(1);
                        end
                        if (r_cmd.do_look) begin
                            n_is_look = 1'b1;
                            n_state   = ST_PROBE_GO;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else if (w_hit) begin
                        n_stamp = r_rd.stamp;
                        n_state = ST_DIV_GO;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_next_addr;
                    n_addr    = w_next_addr;
                    n_steps   = r_steps + IDX_W'(1);
                end
            end
            ST_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    if ((i_min_latency != '0) && (w_quo <= LAT_W'(i_min_latency))) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid) begin
                    n_out_valid        = 1'b1;
                    n_out.cpu_out      = r_cmd.cpu_index;
                    n_out.incoming_out = r_cmd.look_id;
                    n_out.outgoing_out = r_cmd.outgoing_id;
                    n_out.latency_us   = w_quo;
                    n_count            = r_count - CNT_W'(1);
                    n_hole             = r_addr;
                    n_addr             = w_next_addr;
                    n_state            = ST_DEL_RD;
                end
            end
            ST_DEL_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_DEL_EVAL;
            end
            ST_DEL_EVAL: begin
                // The hole slot itself still holds the freed entry, so it
                // counts as empty when the scan wraps back to it.
                if (!r_rd.valid || (r_addr == r_hole)) begin
                    n_state = ST_DEL_END;
                end else begin
                    if (w_move) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_hole;
                        n_hole    = r_addr;
                    end
                    n_addr  = w_next_addr;
                    n_state = ST_DEL_RD;
                end
            end
            ST_DEL_END: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_hole;
                w_wr_data = '0;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_is_look <= n_is_look;
        r_steps   <= n_steps;
        r_hole    <= n_hole;
        r_stamp   <= n_stamp;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("table occupancy above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> ((r_count == '0) && !r_out_valid))
        else $error("table or result register busy during clearing pass");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_rd_en) |-> (w_wr_addr != w_rd_addr))
        else $error("table read and written at the same slot in one cycle");

endmodule

FILE: rtl/run_queue_latency_monitor.sv
// Top level of the run queue latency monitor.
`timescale 1ns / 1ps

// The monitor measures how long tasks wait on a run queue. A wakeup event
// (mode 0) stamps the event time for its task in a 1024-entry table; a
// context switch (mode 1) first stamps the outgoing task when it was
// preempted while runnable, then looks up the incoming task, and on a hit
// reports the wait in whole microseconds when it exceeds min_latency_us
// (or always when that register is 0) and freeing the entry; a hit that is
// not reported leaves its entry in place. Task id 0 is never stamped, a
// nonzero target_task restricts stamping to that one id, and a new id that
// finds the table full is dropped. Events enter a two-deep command queue,
// so the input keeps taking transfers until that queue is full, also while
// the table engine works and while a result waits on the output register.
// The table is a single memory with one read and one write port, organized
// as a hash table with linear probing; its port sets the pace. A stamp or
// a lookup first reads the home slot of its id and then probes slot by
// slot until it finds the id or an empty slot or has visited every slot; a
// switch that stamps the outgoing task does so ahead of its lookup. A hit
// then runs the divider (a start step, four 32 by 32 bit partial products
// of a reciprocal multiplication and a finish step), loads the result once
// the output register is free, and for a reported hit reads and checks each
// following slot in turn, shifting later entries back into the freed slot,
// and finally clears the last hole. After reset the table is swept clear,
// one slot at a time, before the first event is processed; events are
// queued meanwhile and configuration writes are taken at any time.
module run_queue_latency_monitor
    import rqlm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [MIN_W-1:0] r_min_latency;
    logic [ID_W-1:0]  r_target_task;
    logic             w_cmd_valid;
    logic             w_cmd_ready;
    t_cmd             w_cmd;

    // Configuration registers. Writes to indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_latency <= '0;
            r_target_task <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_LATENCY: begin
                    r_min_latency <= i_cfg_data[MIN_W-1:0];
                end
                CFG_TARGET_TASK: begin
                    r_target_task <= i_cfg_data[ID_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front classifies each event into a stamp and a lookup request;
    // events that need neither are consumed without reaching the table.
    rqlm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data        (i_data),
        .i_target_task (r_target_task),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    // The back owns the table, the divider and the output register.
    rqlm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd         (w_cmd),
        .i_min_latency (r_min_latency),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data        (o_data)
    );

endmodule
